// ===== design/sipq_pkg.sv =====
// Shared types, constants and index helpers for the sorted-insert priority queue.
package sipq_pkg;

    localparam int DEPTH   = 512;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = 10;
    localparam int VALUE_W = 32;
    localparam int PRI_W   = 16;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(500);
    localparam logic [CNT_W-1:0] DEPTH_CNT      = CNT_W'(DEPTH);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_HEAD_RD,
        ST_HEAD_WAIT
    } state_t;

    typedef struct packed {
        logic                    mode;
        logic [VALUE_W-1:0]      value;
        logic signed [PRI_W-1:0] priority_req;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] head_value;
        logic               head_valid;
        logic [CNT_W-1:0]   count;
        logic               full_res;
    } out_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]      value;
        logic signed [PRI_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        slot_t             wr_data;
    } ram_req_t;

    // clamp a written capacity to 1..DEPTH
    function automatic logic [CNT_W-1:0] cap_clamp(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > DEPTH_CNT)
            r = DEPTH_CNT;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cap_last(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] m;
        m = c - CNT_W'(1);
        return m[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] idx_inc(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0] c);
        logic [ADDR_W-1:0] r;
        if (idx == cap_last(c))
            r = '0;
        else
            r = idx + ADDR_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] idx_dec(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0] c);
        logic [ADDR_W-1:0] r;
        if (idx == '0)
            r = cap_last(c);
        else
            r = idx - ADDR_W'(1);
        return r;
    endfunction

endpackage

// ===== design/sorted_insert_priority_queue_unit.sv =====
// Top level of the sorted-insert priority queue: sequencer, slot RAM and result register.
//
// A bounded priority queue held sorted in a circular slot RAM (value and priority).
// in channel (in_valid/in_ready/in_data): one word per operation, mode 0 enqueues
// value with priority_req, mode 1 drops the head. out channel (out_valid/out_ready/
// out_data): exactly one word per operation with status, head value/valid, count and
// full flag after the operation. cfg_we/cfg_data write the capacity and empty the queue.
// A dequeue or a rejected operation goes from accept through ST_HEAD_RD and
// ST_HEAD_WAIT to out_valid. An enqueue scans from the tail toward the head and stops
// at the head (at once if the queue is empty) or on an entry of equal or higher
// priority, moving each lower-priority entry it passes (0 .. capacity-1 of them) one
// slot toward the tail, then writes the new entry and reads the head; the scan moves
// one entry per cycle through the single read and single write port of the slot RAM.
// One operation is in work at a time; the next word is accepted as soon as the previous
// result has moved into the output register, even while that result is still stalled.
// A stalled receiver holds out_data steady; with the output register full the sequencer
// waits holding its result until out_ready frees the register.
// Reset (rst_n, async, active low) empties the queue with capacity 500; the RAM is not
// cleared and needs no sweep, a slot's data is only used after being written.
module sorted_insert_priority_queue_unit
    import sipq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data
);

    ram_req_t  ram_req;
    slot_t     ram_rd_data;
    logic      res_valid;
    logic      res_ready;
    out_word_t res_data;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;

    sipq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    sipq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P ($bits(slot_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/sipq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
module sipq_ram #(
    parameter int DEPTH_P = 512,
    parameter int WIDTH_P = 48
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
    input  logic [WIDTH_P-1:0]         wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
    output logic [WIDTH_P-1:0]         rd_data
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sipq_ctrl.sv =====
// Queue sequencer: head/tail/count registers and the read-modify-write insertion scan.
module sipq_ctrl
    import sipq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output out_word_t        res_data,
    output ram_req_t         ram_req,
    input  slot_t            ram_rd_data
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    status_t           status_reg, status_next;
    slot_t             new_reg, new_next;

    logic [ADDR_W-1:0] pos_dec;
    logic [CNT_W-1:0]  cfg_cap;

    assign pos_dec = idx_dec(pos_reg, cap_reg);
    assign cfg_cap = cap_clamp(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cap_reg    <= CAPACITY_RESET;
            head_reg   <= cap_last(CAPACITY_RESET);
            tail_reg   <= cap_last(CAPACITY_RESET);
            count_reg  <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        new_reg <= new_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        new_next    = new_reg;
        ram_req     = '0;
        in_ready    = (state_reg == ST_IDLE);
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.value = in_data.value;
                    new_next.prio  = in_data.priority_req;
                    status_next    = STATUS_DONE;
                    state_next     = ST_HEAD_RD;
                    if (in_data.mode == MODE_ENQ)
                    begin
                        if (count_reg == cap_reg)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            pos_next = tail_reg;
                            if (tail_reg == head_reg)
                            begin
                                state_next = ST_INSERT;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = tail_reg;
                                state_next      = ST_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            head_next  = idx_inc(head_reg, cap_reg);
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // entry at pos is in rd data; move it down if strictly lower priority
                if (new_reg.prio > ram_rd_data.prio)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = idx_inc(pos_reg, cap_reg);
                    ram_req.wr_data = ram_rd_data;
                    pos_next        = pos_dec;
                    if (pos_dec == head_reg)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = pos_dec;
                    end
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_inc(pos_reg, cap_reg);
                ram_req.wr_data = new_reg;
                tail_next       = idx_inc(tail_reg, cap_reg);
                count_next      = count_reg + CNT_W'(1);
                state_next      = ST_HEAD_RD;
            end

            ST_HEAD_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_inc(head_reg, cap_reg);
                state_next      = ST_HEAD_WAIT;
            end

            ST_HEAD_WAIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the queue; the user must issue it only while idle, the block does not enforce this
        if (cfg_we)
        begin
            cap_next   = cfg_cap;
            head_next  = cap_last(cfg_cap);
            tail_next  = cap_last(cfg_cap);
            count_next = '0;
        end
    end

    always_comb
    begin
        res_data.status     = status_reg;
        res_data.head_valid = (count_reg != '0);
        res_data.head_value = (count_reg != '0) ? ram_rd_data.value : '0;
        res_data.count      = count_reg;
        res_data.full_res   = (count_reg == cap_reg);
    end

endmodule
